@@ rtl/core/assert_macros.svh @@
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked each cycle outside reset
`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ rtl/core/sacache_pkg.sv @@
// ----------------------------------------------------------------------------
// sacache_pkg
// Types and constants shared by the set-associative cache model.
// ----------------------------------------------------------------------------
package sacache_pkg;
  localparam int unsigned ADDR_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INDEX_BITS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WAYS_USED = 2'd2;
  localparam logic [1:0] REQ_WRITE = 2'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [ADDR_WIDTH-1:0] address;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [2:0] way;
    logic wrote_back;
    logic [COUNT_WIDTH-1:0] access_count;
    logic [COUNT_WIDTH-1:0] hit_count;
    logic [COUNT_WIDTH-1:0] miss_count;
    logic [COUNT_WIDTH-1:0] writeback_count;
  } resp_t;
endpackage

@@ rtl/core/set_assoc_cache_lru_writeback.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_writeback
// Tag/state model of a write-back, write-allocate LRU cache.
// ----------------------------------------------------------------------------
// At the accepting edge the set's tag row and state row (valid, dirty, recency)
// are read from two synchronous memories. The next cycle compares tags, writes
// both rows back and bumps the counters; the hit, way and writeback flags are
// registered, and the result register loads from them in the pending state.
// The input stalls until the result register loads and while a result waits
// unaccepted, so a new transaction is not accepted before the last one's result
// has loaded. After reset and after a write to any of the three configuration
// registers, a clearing pass over all MAX_SETS sets (256 by default) resets the
// state row of every set; input and configuration stall during it. A pending
// configuration write also holds the input.
`include "assert_macros.svh"
module set_assoc_cache_lru_writeback
  import sacache_pkg::*;
#(
  parameter int unsigned MAX_WAYS = 8,
  parameter int unsigned MAX_SETS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output resp_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  localparam int unsigned SetW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned IbLim = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned RowW = MAX_WAYS * ADDR_WIDTH;
  localparam int unsigned OrdW = MAX_WAYS * WayW;
  localparam int unsigned StW = 2 * MAX_WAYS + OrdW;

  logic [3:0] offset_bits, index_bits, ways_used;
  logic [RowW-1:0] tag_mem [MAX_SETS];
  logic [StW-1:0] st_mem [MAX_SETS];

  logic busy;
  logic [SetW-1:0] set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic wr_q;
  logic [RowW-1:0] row_rd, row_next;
  logic [StW-1:0] st_rd, st_next;
  logic res_pend;
  logic clearing;
  logic [SetW-1:0] clr_idx;
  logic [OrdW-1:0] ord_init;

  logic [3:0] ib_eff;
  logic [4:0] nways;
  logic [ADDR_WIDTH-1:0] blk, tag_c;
  logic [SetW-1:0] set_c;

  logic [MAX_WAYS-1:0] vrow, drow, vrow_next, drow_next;
  logic [OrdW-1:0] ord;
  logic hit_c, found_c, wb_c;
  logic [WayW-1:0] way_c, lru_c;
  logic [OrdW-1:0] ord_next;
  logic [MAX_WAYS-1:0] pos_hit;

  logic [COUNT_WIDTH-1:0] acc_cnt, hit_cnt, miss_cnt, wb_cnt;
  logic r_hit, r_wb;
  logic [WayW-1:0] r_way;
  logic cfg_wr, cfg_clr;

  assign cfg_ready = !busy && !res_pend && !clearing;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign cfg_clr = cfg_wr && (cfg_index == REG_OFFSET_BITS ||
                              cfg_index == REG_INDEX_BITS || cfg_index == REG_WAYS_USED);
  assign in_stall = busy || res_pend || clearing || cfg_valid || (out_valid && out_stall);

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) ord_init[i*WayW +: WayW] = WayW'(i);
  end

  always_comb begin
    ib_eff = (index_bits > 4'(IbLim)) ? 4'(IbLim) : index_bits;
    nways = (ways_used == 4'd0) ? 5'd1 : {1'b0, ways_used};
    if (nways > 5'(MAX_WAYS)) nways = 5'(MAX_WAYS);
    blk = in_data.address >> offset_bits;
    set_c = SetW'(blk & ((ADDR_WIDTH'(1) << ib_eff) - ADDR_WIDTH'(1)));
    tag_c = blk >> ib_eff;
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      row_rd <= tag_mem[set_c];
      st_rd <= st_mem[set_c];
      set_q <= set_c;
      tag_q <= tag_c;
      wr_q <= (in_data.req_type == REQ_WRITE);
    end
    if (clearing) begin
      st_mem[clr_idx] <= {ord_init, {(2 * MAX_WAYS){1'b0}}};
    end else if (busy) begin
      tag_mem[set_q] <= row_next;
      st_mem[set_q] <= st_next;
    end
  end

  always_comb begin
    vrow = st_rd[MAX_WAYS-1:0];
    drow = st_rd[2*MAX_WAYS-1:MAX_WAYS];
    ord = st_rd[StW-1:2*MAX_WAYS];
    hit_c = 1'b0;
    found_c = 1'b0;
    way_c = '0;
    lru_c = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (5'(w) < nways && vrow[w] &&
          row_rd[w*ADDR_WIDTH +: ADDR_WIDTH] == tag_q) begin
        hit_c = 1'b1;
        way_c = WayW'(w);
      end
    end
    if (!hit_c) begin
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
        if (5'(w) < nways && !vrow[w]) begin
          found_c = 1'b1;
          way_c = WayW'(w);
        end
      end
      if (!found_c) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (5'(ord[i*WayW +: WayW]) < nways) lru_c = ord[i*WayW +: WayW];
        end
        way_c = lru_c;
      end
    end
    wb_c = !hit_c && !found_c && drow[way_c];
    for (int i = 0; i < MAX_WAYS; i++) pos_hit[i] = (ord[i*WayW +: WayW] == way_c);
    ord_next = ord;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if ((pos_hit >> i) != '0) ord_next[i*WayW +: WayW] = ord[(i-1)*WayW +: WayW];
    end
    ord_next[WayW-1:0] = way_c;
    row_next = row_rd;
    row_next[way_c*ADDR_WIDTH +: ADDR_WIDTH] = tag_q;
    vrow_next = vrow;
    vrow_next[way_c] = 1'b1;
    drow_next = drow;
    drow_next[way_c] = hit_c ? (drow[way_c] | wr_q) : wr_q;
    st_next = {ord_next, drow_next, vrow_next};
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clr) begin
      clearing <= 1'b1;
      clr_idx <= '0;
    end else if (clearing) begin
      if (clr_idx == SetW'(MAX_SETS - 1)) clearing <= 1'b0;
      clr_idx <= clr_idx + SetW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 4'd6;
      index_bits <= 4'd6;
      ways_used <= 4'(MAX_WAYS > 15 ? 15 : MAX_WAYS);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_INDEX_BITS: index_bits <= cfg_data;
        REG_WAYS_USED: ways_used <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      res_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= in_valid && !in_stall;
      if (busy) res_pend <= 1'b1;
      else if (res_pend) res_pend <= 1'b0;
      if (res_pend) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (busy) begin
      r_hit <= hit_c;
      r_way <= way_c;
      r_wb <= wb_c;
    end
  end

  sacache_counters #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt (
    .clk(clk), .rst(rst), .clear(cfg_clr), .bump(busy),
    .is_hit(hit_c), .is_wb(wb_c),
    .acc_cnt(acc_cnt), .hit_cnt(hit_cnt), .miss_cnt(miss_cnt), .wb_cnt(wb_cnt)
  );

  always_ff @(posedge clk) begin
    if (res_pend) begin
      out_data.hit <= r_hit;
      out_data.way <= 3'(r_way);
      out_data.wrote_back <= r_wb;
      out_data.access_count <= acc_cnt;
      out_data.hit_count <= hit_cnt;
      out_data.miss_count <= miss_cnt;
      out_data.writeback_count <= wb_cnt;
    end
  end

  `ASSERT_IMPL(a_no_overlap, clk, rst, busy, !res_pend, "issue overlaps result")
  `ASSERT_NEXT(a_busy_pend, clk, rst, busy, res_pend, "lookup lost")
  `ASSERT_IMPL(a_cfg_idle, clk, rst, cfg_wr, !busy, "config during lookup")
  `ASSERT_IMPL(a_clear_idle, clk, rst, clearing, !busy, "lookup during clearing")
endmodule

@@ rtl/core/sacache_counters.sv @@
// ----------------------------------------------------------------------------
// sacache_counters
// Saturating access, hit, miss and writeback counters.
// ----------------------------------------------------------------------------
module sacache_counters #(
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic bump,
  input  logic is_hit,
  input  logic is_wb,
  output logic [COUNT_WIDTH-1:0] acc_cnt,
  output logic [COUNT_WIDTH-1:0] hit_cnt,
  output logic [COUNT_WIDTH-1:0] miss_cnt,
  output logic [COUNT_WIDTH-1:0] wb_cnt
);
  function automatic logic [COUNT_WIDTH-1:0] sat(input logic [COUNT_WIDTH-1:0] c);
    sat = (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc_cnt <= '0;
      hit_cnt <= '0;
      miss_cnt <= '0;
      wb_cnt <= '0;
    end else if (bump) begin
      acc_cnt <= sat(acc_cnt);
      if (is_hit) hit_cnt <= sat(hit_cnt);
      else miss_cnt <= sat(miss_cnt);
      if (is_wb) wb_cnt <= sat(wb_cnt);
    end
  end
endmodule
